FILE: rtl/npcs_pkg.sv
package npcs_pkg;

    localparam int NPCS_PALETTE_SIZE = 256;

    // squared distance in 1/256 units, three 12-bit differences squared and summed
    localparam int NPCS_DIST_W = 26;
    localparam logic [NPCS_DIST_W-1:0] NPCS_DIST_LIMIT = 26'd25600000;

    localparam int NPCS_CFG_IDX_W = 1;
    localparam logic [NPCS_CFG_IDX_W-1:0] CFG_BAND_START = 1'd0;
    localparam logic [NPCS_CFG_IDX_W-1:0] CFG_BAND_END   = 1'd1;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_ALL      = 2'd1;
    localparam logic [1:0] CMD_IN_BAND  = 2'd2;
    localparam logic [1:0] CMD_OUT_BAND = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // travels alongside each palette entry through the distance pipeline
    typedef struct packed {
        logic       valid;
        logic [7:0] idx;
    } t_tag;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

FILE: rtl/npcs_dist.sv
module npcs_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [11:0]                     i_query_red,
    input  logic [11:0]                     i_query_green,
    input  logic [11:0]                     i_query_blue,
    input  npcs_pkg::t_rgb                  i_entry,
    input  npcs_pkg::t_tag                  i_tag,
    output logic [npcs_pkg::NPCS_DIST_W-1:0] o_dist,
    output npcs_pkg::t_tag                  o_tag
);
    import npcs_pkg::*;

    logic [11:0] w_d_red;
    logic [11:0] w_d_green;
    logic [11:0] w_d_blue;

    logic [23:0] r_sq_red;
    logic [23:0] r_sq_green;
    logic [23:0] r_sq_blue;
    t_tag        r_sq_tag;

    logic [NPCS_DIST_W-1:0] r_dist;
    t_tag                   r_dist_tag;

    function automatic logic [11:0] abs_diff(input logic [11:0] q, input logic [7:0] p);
        logic [11:0] b;
        b = {p, 4'b0000};
        abs_diff = (q >= b) ? (q - b) : (b - q);
    endfunction

    assign w_d_red   = abs_diff(i_query_red,   i_entry.red);
    assign w_d_green = abs_diff(i_query_green, i_entry.green);
    assign w_d_blue  = abs_diff(i_query_blue,  i_entry.blue);

    always_ff @(posedge i_clk) begin
        r_sq_red   <= w_d_red * w_d_red;
        r_sq_green <= w_d_green * w_d_green;
        r_sq_blue  <= w_d_blue * w_d_blue;
        r_sq_tag.idx <= i_tag.idx;
        r_dist <= NPCS_DIST_W'(r_sq_red) + NPCS_DIST_W'(r_sq_green)
                + NPCS_DIST_W'(r_sq_blue);
        r_dist_tag.idx <= r_sq_tag.idx;
        if (!i_rst_n) begin
            r_sq_tag.valid   <= 1'b0;
            r_dist_tag.valid <= 1'b0;
        end else begin
            r_sq_tag.valid   <= i_tag.valid;
            r_dist_tag.valid <= r_sq_tag.valid;
        end
    end

    assign o_dist = r_dist;
    assign o_tag  = r_dist_tag;

endmodule

FILE: rtl/nearest_palette_color_search_top.sv
// Nearest palette colour search.
// Input channel (i_in_valid / o_in_stall) carries write and query beats.
// A write beat (cmd 0) stores one palette entry and gives no result;
// writes to an index at or beyond PALETTE_SIZE are dropped.
// A query beat (cmd 1..3) sweeps the palette memory, one entry per cycle
// through its single read port, into a three-stage distance pipeline and a
// running minimum; cmd 1 sweeps from entry 0, cmds 2 and 3 from entry 1.
// The result is loaded into the output register once the sweep has drained;
// the next beat is taken in the cycle after the result is loaded, so
// queries do not overlap.
// Output channel (o_out_valid / i_out_stall) is a result register: a new beat
// is accepted while a result waits, but a finished search holds until the
// register is free. Write the band registers (i_cfg_we / i_cfg_index /
// i_cfg_data) only while idle; the block does not enforce this. Reset clears
// the band registers and control state; palette contents are undefined until
// written and must be written before they are queried.
module nearest_palette_color_search_top #(
    parameter int PALETTE_SIZE = npcs_pkg::NPCS_PALETTE_SIZE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [npcs_pkg::NPCS_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [7:0]                          i_entry_index,
    input  logic [7:0]                          i_entry_red,
    input  logic [7:0]                          i_entry_green,
    input  logic [7:0]                          i_entry_blue,
    input  logic [11:0]                         i_query_red,
    input  logic [11:0]                         i_query_green,
    input  logic [11:0]                         i_query_blue,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_nearest_index,
    output logic                                o_matched
);
    import npcs_pkg::*;

    localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_SIZE - 1);

    t_rgb r_mem [PALETTE_SIZE];

    t_state r_state, n_state;

    logic [7:0]  r_band_start;
    logic [7:0]  r_band_end;
    logic [1:0]  r_cmd;
    logic [11:0] r_q_red;
    logic [11:0] r_q_green;
    logic [11:0] r_q_blue;

    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [1:0]    r_drain, n_drain;
    t_rgb          r_rd_data;
    t_tag          r_rd_tag;

    logic [NPCS_DIST_W-1:0] r_best;
    logic [7:0]             r_pick;
    logic                   r_hit;

    logic r_out_valid;
    logic [7:0] r_out_index;
    logic r_out_matched;

    logic w_accept;
    logic w_write;
    logic w_query;
    logic w_wr_ok;
    logic w_in_band;
    logic w_elig;
    logic w_load;
    logic [7:0] w_idx8;
    logic [7:0] w_fallback;

    logic [NPCS_DIST_W-1:0] w_dist;
    t_tag                   w_dist_tag;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_write  = w_accept && (i_cmd == CMD_WRITE);
    assign w_query  = w_accept && (i_cmd != CMD_WRITE);
    assign w_wr_ok  = {1'b0, i_entry_index} < 9'(PALETTE_SIZE);

    assign w_idx8    = 8'(r_rd_idx);
    assign w_in_band = (w_idx8 >= r_band_start) && (w_idx8 <= r_band_end);
    always_comb begin
        case (r_cmd)
            CMD_ALL:      w_elig = 1'b1;
            CMD_IN_BAND:  w_elig = w_in_band;
            CMD_OUT_BAND: w_elig = !w_in_band;
            default:      w_elig = 1'b0;
        endcase
    end

    always_comb begin
        case (i_cmd)
            CMD_IN_BAND:  w_fallback = r_band_start;
            CMD_OUT_BAND: w_fallback = 8'd1;
            default:      w_fallback = 8'd0;
        endcase
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_write && w_wr_ok) begin
            r_mem[i_entry_index[AW-1:0]] <= {i_entry_red, i_entry_green, i_entry_blue};
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_start <= '0;
            r_band_end   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BAND_START: r_band_start <= i_cfg_data;
                CFG_BAND_END:   r_band_end   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_cmd     <= i_cmd;
            r_q_red   <= i_query_red;
            r_q_green <= i_query_green;
            r_q_blue  <= i_query_blue;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rd_idx = r_rd_idx;
        n_drain  = r_drain;
        w_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state  = S_SCAN;
                    n_rd_idx = (i_cmd == CMD_ALL) ? '0 : AW'(1);
                end
            end
            S_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                    n_drain = '0;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                // wait for the last entry to clear read, square and sum stages
                if (r_drain == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain + 2'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_drain      <= n_drain;
        r_rd_tag.idx <= w_idx8;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rd_tag.valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rd_tag.valid <= (r_state == S_SCAN) && w_elig;
        end
    end

    npcs_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_query_red   (r_q_red),
        .i_query_green (r_q_green),
        .i_query_blue  (r_q_blue),
        .i_entry       (r_rd_data),
        .i_tag         (r_rd_tag),
        .o_dist        (w_dist),
        .o_tag         (w_dist_tag)
    );

    // running minimum, strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (w_query) begin
            r_best <= NPCS_DIST_LIMIT;
            r_pick <= w_fallback;
            r_hit  <= 1'b0;
        end else if (w_dist_tag.valid && (w_dist < r_best)) begin
            r_best <= w_dist;
            r_pick <= w_dist_tag.idx;
            r_hit  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_index   <= r_pick;
            r_out_matched <= r_hit;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_index;
    assign o_matched       = r_out_matched;

endmodule
